>>> rtl/fcd_pkg.sv
package fcd_pkg;

    // Default sizing of the grid store and of the frame counters.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Register values after reset.
    localparam int GRID_WIDTH_RESET  = 1024;
    localparam int GRID_HEIGHT_RESET = 1024;

    // Port widths fixed by the interface.
    localparam int GRID_WIDTH_BITS  = 11;
    localparam int GRID_HEIGHT_BITS = 13;
    localparam int CFG_DATA_BITS    = 13;
    localparam int CELL_X_BITS      = 10;
    localparam int CELL_Y_BITS      = 12;

    // Request kinds on the input channel.
    localparam logic REQ_CELL  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Configuration register indexes.
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CLS_FREE     = 2'd0,
        CLS_UNKNOWN  = 2'd1,
        CLS_OCCUPIED = 2'd2
    } cls_t;

    // One line-store entry: the classes of one column in the two rows
    // above the row now arriving.
    typedef struct packed {
        cls_t older;
        cls_t newer;
    } line_pair_t;

    // One column of the 3x3 window.
    typedef struct packed {
        cls_t top;
        cls_t mid;
        cls_t bot;
    } win_col_t;

    function automatic cls_t classify(input logic signed [7:0] value);
        cls_t c;
        if (value == 8'sd0) begin
            c = CLS_FREE;
        end else if (value == -8'sd1) begin
            c = CLS_UNKNOWN;
        end else begin
            c = CLS_OCCUPIED;
        end
        return c;
    endfunction

endpackage

>>> rtl/fcd_line_buf.sv
module fcd_line_buf
    import fcd_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output line_pair_t               rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  line_pair_t               wr_data
);

    line_pair_t mem_reg [DEPTH];
    line_pair_t raw_reg;
    line_pair_t byp_data_reg;
    logic       byp_reg;

    // A read that meets a write to the same entry returns the new data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            raw_reg      <= mem_reg[rd_addr];
            byp_reg      <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : raw_reg;

endmodule

>>> rtl/frontier_cell_detect.sv
// Streaming 3x3 frontier detector for an occupancy grid.
// Requests on the s_ channel carry either one grid cell (s_req_type = 0) in raster
// order, row 0 first and column 0 first within a row, or a drain tick (s_req_type = 1).
// A free cell (value 0) is a frontier when any in-bounds neighbor is unknown (-1).
// The verdict for a cell, with its column and row, is produced by the request that
// arrives grid_width+1 requests after that cell; after the last cell of a frame,
// grid_width+1 drain ticks flush the tail, and m_frame_last marks the final cell.
// Drain ticks sent before the frame is complete are accepted and dropped.
// The block takes one request per clock unless the output stalls; the line store
// has one read and one write port, each cell read and written once, setting that rate.
// A result is formed in the input stage and leaves through the output register.
// An output register and an input stage part the two sides, so a stalled receiver
// stops the input only once both stages hold a request.
// Reset sets the grid to 1024 by 1024 (clamped to the parameters) and starts a new
// frame; the line store needs no clearing. Writing either configuration register
// also starts a new frame and must happen only while the block is idle.
module frontier_cell_detect
    import fcd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_req_type,
    input  logic signed [7:0]        s_cell_value,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CELL_X_BITS-1:0]   m_cell_x,
    output logic [CELL_Y_BITS-1:0]   m_cell_y,
    output logic                     m_is_frontier,
    output logic                     m_frame_last
);

    // Widths that follow from the grid limits.
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int RIW = $clog2(MAX_HEIGHT + 2);

    localparam int W_RESET = (GRID_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_WIDTH_RESET;
    localparam int H_RESET = (GRID_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : GRID_HEIGHT_RESET;

    // Grid size, already clamped into the supported range.
    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [WW-1:0] w_cfg;
    logic [HW-1:0] h_cfg;
    logic [GRID_WIDTH_BITS-1:0]  cfg_w_field;
    logic [GRID_HEIGHT_BITS-1:0] cfg_h_field;

    // Frame counters: position of the incoming cell and of the next cell judged.
    logic [XW-1:0]  col_in_reg,  col_in_next;
    logic [RIW-1:0] row_in_reg,  row_in_next;
    logic [XW-1:0]  x_out_reg,   x_out_next;
    logic [YW-1:0]  y_out_reg,   y_out_next;

    logic [XW-1:0] w_last_col;
    logic [YW-1:0] h_last_row;
    logic          in_frame;
    logic          s_accept;
    logic          adv;
    logic          has_res;
    logic          out_last;
    cls_t          in_cls;

    // Input stage: one request that advances the frame, waiting for its line-store read.
    logic          b_valid_reg;
    cls_t          b_cls_reg;
    logic [XW-1:0] b_addr_reg;
    logic          b_res_reg;
    logic          b_last_reg;
    logic [XW-1:0] b_x_reg;
    logic [YW-1:0] b_y_reg;
    logic          b_left_ok_reg;
    logic          b_right_ok_reg;
    logic          b_top_ok_reg;
    logic          b_bot_ok_reg;
    logic          b_move;

    // Output stage.
    logic          c_valid_reg;
    logic [XW-1:0] c_x_reg;
    logic [YW-1:0] c_y_reg;
    logic          c_frontier_reg;
    logic          c_last_reg;
    logic          c_free;

    // The two most recent window columns; index 0 is the older one.
    win_col_t      win_reg [2];
    win_col_t      new_col;
    line_pair_t    lb_rd;
    line_pair_t    lb_wr;
    logic          near_unknown;
    logic          frontier;

    //--------------------------------------------------------------------------
    // Configuration
    //--------------------------------------------------------------------------
    assign cfg_w_field = cfg_wdata[GRID_WIDTH_BITS-1:0];
    assign cfg_h_field = cfg_wdata[GRID_HEIGHT_BITS-1:0];

    always_comb begin
        if (cfg_w_field == '0) begin
            w_cfg = WW'(1);
        end else if (32'(cfg_w_field) > 32'(MAX_WIDTH)) begin
            w_cfg = WW'(MAX_WIDTH);
        end else begin
            w_cfg = WW'(cfg_w_field);
        end
        if (cfg_h_field == '0) begin
            h_cfg = HW'(1);
        end else if (32'(cfg_h_field) > 32'(MAX_HEIGHT)) begin
            h_cfg = HW'(MAX_HEIGHT);
        end else begin
            h_cfg = HW'(cfg_h_field);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= WW'(W_RESET);
            h_reg <= HW'(H_RESET);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRID_WIDTH:  w_reg <= w_cfg;
                REG_GRID_HEIGHT: h_reg <= h_cfg;
                default:         w_reg <= w_reg;
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // Request intake and frame counters
    //--------------------------------------------------------------------------
    assign c_free   = !c_valid_reg || m_ready;
    assign b_move   = b_valid_reg && c_free;
    assign s_ready  = !b_valid_reg || c_free;
    assign s_accept = s_valid && s_ready;

    assign w_last_col = XW'(w_reg - 1'b1);
    assign h_last_row = YW'(h_reg - 1'b1);
    assign in_frame   = row_in_reg < RIW'(h_reg);

    // A drain tick that arrives while cells are still expected changes nothing.
    assign adv = s_accept && !(in_frame && (s_req_type == REQ_DRAIN));

    // A verdict is due once the cell below and right of the judged one has arrived.
    assign has_res  = (row_in_reg > RIW'(1)) || ((row_in_reg == RIW'(1)) && (col_in_reg != '0));
    assign out_last = (x_out_reg == w_last_col) && (y_out_reg == h_last_row);

    // Past the frame, any request is a drain tick and its value is not stored.
    assign in_cls = in_frame ? classify(s_cell_value) : CLS_OCCUPIED;

    always_comb begin
        col_in_next = col_in_reg;
        row_in_next = row_in_reg;
        x_out_next  = x_out_reg;
        y_out_next  = y_out_reg;
        if (cfg_we || (adv && has_res && out_last)) begin
            col_in_next = '0;
            row_in_next = '0;
            x_out_next  = '0;
            y_out_next  = '0;
        end else if (adv) begin
            if (col_in_reg == w_last_col) begin
                col_in_next = '0;
                row_in_next = row_in_reg + 1'b1;
            end else begin
                col_in_next = col_in_reg + 1'b1;
            end
            if (has_res) begin
                if (x_out_reg == w_last_col) begin
                    x_out_next = '0;
                    y_out_next = y_out_reg + 1'b1;
                end else begin
                    x_out_next = x_out_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_in_reg <= '0;
            row_in_reg <= '0;
            x_out_reg  <= '0;
            y_out_reg  <= '0;
        end else begin
            col_in_reg <= col_in_next;
            row_in_reg <= row_in_next;
            x_out_reg  <= x_out_next;
            y_out_reg  <= y_out_next;
        end
    end

    //--------------------------------------------------------------------------
    // Input stage. The judged cell's position decides which neighbors lie
    // inside the grid; the rest are ignored.
    //--------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_ready) begin
            b_valid_reg <= adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_cls_reg      <= in_cls;
            b_addr_reg     <= col_in_reg;
            b_res_reg      <= has_res;
            b_last_reg     <= out_last;
            b_x_reg        <= x_out_reg;
            b_y_reg        <= y_out_reg;
            b_left_ok_reg  <= x_out_reg != '0;
            b_right_ok_reg <= x_out_reg != w_last_col;
            b_top_ok_reg   <= y_out_reg != '0;
            b_bot_ok_reg   <= y_out_reg != h_last_row;
        end
    end

    // The line store keeps, for each column, the two rows above the incoming one.
    fcd_line_buf #(
        .DEPTH   (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (adv),
        .rd_addr (col_in_reg),
        .rd_data (lb_rd),
        .wr_en   (b_move),
        .wr_addr (b_addr_reg),
        .wr_data (lb_wr)
    );

    always_comb begin
        lb_wr.older = lb_rd.newer;
        lb_wr.newer = b_cls_reg;
        new_col.top = lb_rd.older;
        new_col.mid = lb_rd.newer;
        new_col.bot = b_cls_reg;
    end

    //--------------------------------------------------------------------------
    // Window and verdict. With the incoming column on the right, the judged
    // cell is the middle of the newer of the two stored window columns.
    //--------------------------------------------------------------------------
    function automatic logic col_unknown(input win_col_t col, input logic top_ok,
                                         input logic bot_ok);
        return ((col.top == CLS_UNKNOWN) && top_ok) || (col.mid == CLS_UNKNOWN) ||
               ((col.bot == CLS_UNKNOWN) && bot_ok);
    endfunction

    always_comb begin
        near_unknown = (b_left_ok_reg && col_unknown(win_reg[0], b_top_ok_reg, b_bot_ok_reg)) ||
                       col_unknown(win_reg[1], b_top_ok_reg, b_bot_ok_reg) ||
                       (b_right_ok_reg && col_unknown(new_col, b_top_ok_reg, b_bot_ok_reg));
        frontier = (win_reg[1].mid == CLS_FREE) && near_unknown;
    end

    always_ff @(posedge aclk) begin
        if (b_move) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= new_col;
        end
    end

    //--------------------------------------------------------------------------
    // Output register
    //--------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_free) begin
            c_valid_reg <= b_move && b_res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_move) begin
            c_x_reg        <= b_x_reg;
            c_y_reg        <= b_y_reg;
            c_frontier_reg <= frontier;
            c_last_reg     <= b_last_reg;
        end
    end

    assign m_valid       = c_valid_reg;
    assign m_cell_x      = CELL_X_BITS'(c_x_reg);
    assign m_cell_y      = CELL_Y_BITS'(c_y_reg);
    assign m_is_frontier = c_frontier_reg;
    assign m_frame_last  = c_last_reg;

    //--------------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------------
    a_cols_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (WW'(x_out_reg) < w_reg) && (WW'(col_in_reg) < w_reg))
        else $error("column counter beyond grid width");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_in_reg <= (RIW'(h_reg) + RIW'(1)))
        else $error("input row counter beyond frame plus drain");

    a_verdict_lag: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && has_res && (col_in_reg != '0)) |->
            ((XW'(x_out_reg + 1'b1) == col_in_reg) &&
             ((RIW'(y_out_reg) + RIW'(1)) == row_in_reg)))
        else $error("judged cell does not trail the incoming cell by one row and column");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && has_res && out_last) |=>
            ((row_in_reg == '0) && (col_in_reg == '0) &&
             (x_out_reg == '0) && (y_out_reg == '0)))
        else $error("counters not cleared after the frame's last verdict");

endmodule
